### rtl/core/axis_angle_to_euler_unit_macros.svh
// Assertion macros used by the axis-angle to Euler RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef AXIS_ANGLE_TO_EULER_UNIT_MACROS_SVH
`define AXIS_ANGLE_TO_EULER_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define AAE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication after a fixed number of cycles, disabled in reset
`define AAE_ASSERT_DELAY(label, clk, rst, ante, dly, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error(msg);

`endif

### rtl/core/aae_pkg.sv
// Package for the axis-angle to Euler converter: types, fixed-point constants,
// arctangent table. No dependencies.
package aae_pkg;

   // Internal fixed point: signed Q28 in DW bits
   localparam int DW        = 40;
   localparam int FRAC      = 28;
   localparam int TABLE_LEN = 24;
   localparam int CORDIC_ITERATIONS_DEF = 16;

   // Square root: 29 digit steps on a 57-bit radicand
   localparam int SQ_STEPS = 29;
   localparam int SQ_NW    = 57;
   localparam int SQ_RW    = 58;

   localparam logic signed [DW-1:0] ONE_Q     = DW'(1) <<< FRAC;
   localparam logic signed [DW-1:0] PI_Q      = DW'(843314857);
   localparam logic signed [DW-1:0] HALF_PI_Q = DW'(421657428);
   localparam logic signed [DW-1:0] GAIN_Q    = DW'(163008218);

   // Pole bank angles after output rounding
   localparam logic signed [15:0] POLE_BANK_N = 16'((HALF_PI_Q + DW'(16384)) >>> 15);
   localparam logic signed [15:0] POLE_BANK_S =
      16'((DW'(0) - HALF_PI_Q + DW'(16384)) >>> 15);

   // pole_case codes
   localparam logic [1:0] POLE_REGULAR = 2'd0;
   localparam logic [1:0] POLE_NORTH   = 2'd1;
   localparam logic [1:0] POLE_SOUTH   = 2'd2;

   // CSR map
   localparam int   CSR_AW             = 3;
   localparam logic CSR_POLE_THRESHOLD = 1'b0;
   localparam logic [14:0] POLE_THR_RESET = 15'd16351;

   typedef struct packed {
      logic signed [15:0] axis_x;
      logic signed [15:0] axis_y;
      logic signed [15:0] axis_z;
      logic signed [15:0] rotation_angle;
   } req_type;

   typedef struct packed {
      logic signed [15:0] heading_angle;
      logic signed [15:0] attitude_angle;
      logic signed [15:0] bank_angle;
      logic [1:0]         pole_case;
   } rsp_type;

   // Rotation-mode CORDIC state
   typedef struct packed {
      logic signed [DW-1:0] x;
      logic signed [DW-1:0] y;
      logic signed [DW-1:0] ang;
      logic                 neg;
   } rot_type;

   // Vectoring-mode CORDIC state
   typedef struct packed {
      logic signed [DW-1:0] x;
      logic signed [DW-1:0] y;
      logic signed [DW-1:0] z;
      logic                 zero;
   } vec_type;

   // Digit-by-digit square root state
   typedef struct packed {
      logic [SQ_NW-1:0] n;
      logic [SQ_RW-1:0] res;
   } sqrt_type;

   // atan(2^-i) in Q28
   function automatic logic signed [DW-1:0] atan_entry(input int unsigned idx);
      case (idx)
         0:  return DW'(32'h0C90FDAA);
         1:  return DW'(32'h076B19C1);
         2:  return DW'(32'h03EB6EBF);
         3:  return DW'(32'h01FD5BA9);
         4:  return DW'(32'h00FFAADD);
         5:  return DW'(32'h007FF556);
         6:  return DW'(32'h003FFEAA);
         7:  return DW'(32'h001FFFD5);
         8:  return DW'(32'h000FFFFA);
         9:  return DW'(32'h0007FFFF);
         10: return DW'(32'h0003FFFF);
         11: return DW'(32'h0001FFFF);
         12: return DW'(32'h0000FFFF);
         13: return DW'(32'h00007FFF);
         14: return DW'(32'h00003FFF);
         15: return DW'(32'h00001FFF);
         16: return DW'(32'h00000FFF);
         17: return DW'(32'h000007FF);
         18: return DW'(32'h000003FF);
         19: return DW'(32'h000001FF);
         20: return DW'(32'h000000FF);
         21: return DW'(32'h0000007F);
         22: return DW'(32'h0000003F);
         23: return DW'(32'h0000001F);
         default: return '0;
      endcase
   endfunction

endpackage

### rtl/core/aae_rot_cell.sv
// One rotation-mode CORDIC micro-rotation with its output register.
// Depends on aae_pkg.
module aae_rot_cell #(
   parameter int unsigned IDX = 0
) (
   input  logic             clock,
   input  aae_pkg::rot_type prev_data,
   output aae_pkg::rot_type next_data
);
   import aae_pkg::*;

   rot_type step_ff, step_in;

   // Turn toward zero residual angle
   always_comb begin
      step_in.neg = prev_data.neg;
      if (prev_data.ang >= 0) begin
         step_in.x   = prev_data.x - (prev_data.y >>> IDX);
         step_in.y   = prev_data.y + (prev_data.x >>> IDX);
         step_in.ang = prev_data.ang - atan_entry(IDX);
      end else begin
         step_in.x   = prev_data.x + (prev_data.y >>> IDX);
         step_in.y   = prev_data.y - (prev_data.x >>> IDX);
         step_in.ang = prev_data.ang + atan_entry(IDX);
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
   end

   assign next_data = step_ff;
endmodule

### rtl/core/aae_vec_cell.sv
// One vectoring-mode CORDIC micro-rotation with its output register.
// Depends on aae_pkg.
module aae_vec_cell #(
   parameter int unsigned IDX = 0
) (
   input  logic             clock,
   input  aae_pkg::vec_type prev_data,
   output aae_pkg::vec_type next_data
);
   import aae_pkg::*;

   vec_type step_ff, step_in;

   // Drive y toward zero, accumulate angle
   always_comb begin
      step_in.zero = prev_data.zero;
      if (prev_data.y >= 0) begin
         step_in.x = prev_data.x + (prev_data.y >>> IDX);
         step_in.y = prev_data.y - (prev_data.x >>> IDX);
         step_in.z = prev_data.z + atan_entry(IDX);
      end else begin
         step_in.x = prev_data.x - (prev_data.y >>> IDX);
         step_in.y = prev_data.y + (prev_data.x >>> IDX);
         step_in.z = prev_data.z - atan_entry(IDX);
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
   end

   assign next_data = step_ff;
endmodule

### rtl/core/aae_sqrt_cell.sv
// One digit step of the integer square root with its output register.
// Depends on aae_pkg.
module aae_sqrt_cell #(
   parameter int unsigned IDX = 0
) (
   input  logic              clock,
   input  aae_pkg::sqrt_type prev_data,
   output aae_pkg::sqrt_type next_data
);
   import aae_pkg::*;

   localparam logic [SQ_RW-1:0] ROOT_BIT = SQ_RW'(1) << (2 * (SQ_STEPS - 1 - IDX));

   sqrt_type         step_ff, step_in;
   logic [SQ_RW-1:0] trial;

   // Try this digit: subtract res + bit when it fits
   always_comb begin
      trial = prev_data.res + ROOT_BIT;
      if ({1'b0, prev_data.n} >= trial) begin
         step_in.n   = SQ_NW'({1'b0, prev_data.n} - trial);
         step_in.res = (prev_data.res >> 1) + ROOT_BIT;
      end else begin
         step_in.n   = prev_data.n;
         step_in.res = prev_data.res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
   end

   assign next_data = step_ff;
endmodule

### rtl/core/axis_angle_to_euler_unit.sv
// Axis-angle to Euler angle converter, top level.
// Depends on aae_pkg, aae_rot_cell, aae_sqrt_cell, aae_vec_cell and the macro header.
//
// Takes one request per clock (busy is high during reset and in the cycle after it) and
// returns each result through a pipeline, N = min(CORDIC_ITERATIONS, 24), built from
// a sin/cos section of N CORDIC cells, a row of 29 square-root cells and an atan2
// section of N CORDIC cells. Results come out in request order with rsp_valid
// high for exactly one cycle and must be taken then. Write pole_threshold only
// while no request is in flight.
`include "axis_angle_to_euler_unit_macros.svh"

module axis_angle_to_euler_unit #(
   parameter int CORDIC_ITERATIONS = aae_pkg::CORDIC_ITERATIONS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  aae_pkg::req_type          req_data,
   output logic                      rsp_valid,
   output aae_pkg::rsp_type          rsp_data,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [aae_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);
   import aae_pkg::*;

   localparam int N = (CORDIC_ITERATIONS < TABLE_LEN) ? CORDIC_ITERATIONS : TABLE_LEN;
   localparam int LATENCY = 2 * N + 41;
   localparam logic [SQ_NW-1:0] ONE_SQ = SQ_NW'(1) << (2 * FRAC);

   typedef struct packed {
      logic signed [DW-1:0] x;
      logic signed [DW-1:0] y;
      logic signed [DW-1:0] z;
   } xyz_type;

   typedef struct packed {
      logic signed [DW-1:0] head_y;
      logic signed [DW-1:0] head_x;
      logic signed [DW-1:0] att_y;
      logic signed [DW-1:0] att_x;
      logic signed [DW-1:0] vc;
      logic [1:0]           pole;
   } mid_type;

   // Q28 product, floor rounding
   function automatic logic signed [DW-1:0] qmul(input logic signed [DW-1:0] a,
                                                 input logic signed [DW-1:0] b);
      logic signed [33:0] a_t;
      logic signed [33:0] b_t;
      logic signed [67:0] p;
      a_t = a[33:0];
      b_t = b[33:0];
      p   = a_t * b_t;
      return DW'(p >>> FRAC);
   endfunction

   // Fold angle into [-pi/2, pi/2] and load CORDIC start vector
   function automatic rot_type rot_start(input logic signed [DW-1:0] ang);
      rot_type r;
      r.x = GAIN_Q;
      r.y = '0;
      if (ang > HALF_PI_Q) begin
         r.ang = ang - PI_Q;
         r.neg = 1'b1;
      end else if (ang < -HALF_PI_Q) begin
         r.ang = ang + PI_Q;
         r.neg = 1'b1;
      end else begin
         r.ang = ang;
         r.neg = 1'b0;
      end
      return r;
   endfunction

   // atan2 prelude: zero flag, half-turn for negative x
   function automatic vec_type vec_start(input logic signed [DW-1:0] y,
                                         input logic signed [DW-1:0] x);
      vec_type r;
      r.zero = (x == 0) && (y == 0);
      if (x < 0) begin
         r.x = -x;
         r.y = -y;
         r.z = (y >= 0) ? PI_Q : -PI_Q;
      end else begin
         r.x = x;
         r.y = y;
         r.z = '0;
      end
      return r;
   endfunction

   // Round half up to Q3.13 and saturate
   function automatic logic signed [15:0] to_out(input logic signed [DW-1:0] v);
      logic signed [DW-1:0] r;
      r = (v + DW'(16384)) >>> 15;
      if (r > DW'(32767)) return 16'sh7FFF;
      else if (r < DW'(-32768)) return 16'sh8000;
      else return r[15:0];
   endfunction

   // ---------------------------------------------------------------- control
   logic                busy_ff;
   logic [LATENCY-1:0]  vld_ff, vld_in;
   logic                accept;
   logic [14:0]         thr_ff, thr_in;

   assign accept = start && !busy_ff;
   assign vld_in = {vld_ff[LATENCY-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         vld_ff  <= '0;
      end else begin
         busy_ff <= 1'b0;
         vld_ff  <= vld_in;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = vld_ff[LATENCY-1];

   // CSR: pole_threshold
   always_comb begin
      thr_in = thr_ff;
      if (psel && penable && pwrite && paddr[2] == CSR_POLE_THRESHOLD)
         thr_in = pwdata[14:0];
   end

   always_ff @(posedge clock) begin
      if (reset) thr_ff <= POLE_THR_RESET;
      else thr_ff <= thr_in;
   end

   assign prdata = (paddr[2] == CSR_POLE_THRESHOLD) ? {17'b0, thr_ff} : 32'b0;
   assign pready = 1'b1;

   // ---------------------------------------------------------------- S0/S1
   logic signed [DW-1:0] s0_x_ff, s0_y_ff, s0_z_ff, s0_w_ff;
   xyz_type              s1_xyz_ff;
   rot_type              s1_rot_ff, s1_roth_ff;

   always_ff @(posedge clock) begin
      s0_x_ff    <= DW'(req_data.axis_x) <<< 14;
      s0_y_ff    <= DW'(req_data.axis_y) <<< 14;
      s0_z_ff    <= DW'(req_data.axis_z) <<< 14;
      s0_w_ff    <= DW'(req_data.rotation_angle) <<< 15;
      s1_xyz_ff  <= '{x: s0_x_ff, y: s0_y_ff, z: s0_z_ff};
      s1_rot_ff  <= rot_start(s0_w_ff);
      s1_roth_ff <= rot_start(s0_w_ff >>> 1);
   end

   // ---------------------------------------------------------------- sin/cos rows
   rot_type rot_w  [N+1];
   rot_type roth_w [N+1];
   xyz_type xyz_dly_ff [N];

   assign rot_w[0]  = s1_rot_ff;
   assign roth_w[0] = s1_roth_ff;

   for (genvar k = 0; k < N; k++) begin : g_rot
      aae_rot_cell #(.IDX(k)) u_rot (
         .clock(clock), .prev_data(rot_w[k]), .next_data(rot_w[k+1]));
      aae_rot_cell #(.IDX(k)) u_roth (
         .clock(clock), .prev_data(roth_w[k]), .next_data(roth_w[k+1]));
   end

   always_ff @(posedge clock) begin
      xyz_dly_ff[0] <= s1_xyz_ff;
      for (int k = 1; k < N; k++) xyz_dly_ff[k] <= xyz_dly_ff[k-1];
   end

   // ---------------------------------------------------------------- S2..S5 products
   xyz_type              s2_xyz_ff;
   logic signed [DW-1:0] s2_s_ff, s2_t_ff, s2_sh_ff, s2_ch_ff;
   logic signed [DW-1:0] p_xy_ff, p_xz_ff, p_yz_ff, p_xx_ff, p_yy_ff, p_zz_ff;
   logic signed [DW-1:0] p_zs_ff, p_xs_ff, p_ys_ff, p_xsh_ff, s3_t_ff, s3_ch_ff;
   logic signed [DW-1:0] p_xyt_ff, p_yzt_ff, p_xzt_ff, p_xzzt_ff, p_yzzt_ff;
   logic signed [DW-1:0] s4_zs_ff, s4_xs_ff, s4_ys_ff, s4_xsh_ff, s4_ch_ff;
   logic signed [DW-1:0] s5_v_ff, s5_nh_ff, s5_dh_ff, s5_na_ff, s5_da_ff;
   logic signed [DW-1:0] s5_xsh_ff, s5_ch_ff;

   always_ff @(posedge clock) begin
      // sign fix of the folded CORDIC output, t = 1 - cos w
      s2_xyz_ff <= xyz_dly_ff[N-1];
      s2_s_ff   <= rot_w[N].neg ? -rot_w[N].y : rot_w[N].y;
      s2_t_ff   <= rot_w[N].neg ? ONE_Q + rot_w[N].x : ONE_Q - rot_w[N].x;
      s2_sh_ff  <= roth_w[N].neg ? -roth_w[N].y : roth_w[N].y;
      s2_ch_ff  <= roth_w[N].neg ? -roth_w[N].x : roth_w[N].x;
      // first level products
      p_xy_ff   <= qmul(s2_xyz_ff.x, s2_xyz_ff.y);
      p_xz_ff   <= qmul(s2_xyz_ff.x, s2_xyz_ff.z);
      p_yz_ff   <= qmul(s2_xyz_ff.y, s2_xyz_ff.z);
      p_xx_ff   <= qmul(s2_xyz_ff.x, s2_xyz_ff.x);
      p_yy_ff   <= qmul(s2_xyz_ff.y, s2_xyz_ff.y);
      p_zz_ff   <= qmul(s2_xyz_ff.z, s2_xyz_ff.z);
      p_zs_ff   <= qmul(s2_xyz_ff.z, s2_s_ff);
      p_xs_ff   <= qmul(s2_xyz_ff.x, s2_s_ff);
      p_ys_ff   <= qmul(s2_xyz_ff.y, s2_s_ff);
      p_xsh_ff  <= qmul(s2_xyz_ff.x, s2_sh_ff);
      s3_t_ff   <= s2_t_ff;
      s3_ch_ff  <= s2_ch_ff;
      // times t
      p_xyt_ff  <= qmul(p_xy_ff, s3_t_ff);
      p_yzt_ff  <= qmul(p_yz_ff, s3_t_ff);
      p_xzt_ff  <= qmul(p_xz_ff, s3_t_ff);
      p_xzzt_ff <= qmul(p_xx_ff + p_zz_ff, s3_t_ff);
      p_yzzt_ff <= qmul(p_yy_ff + p_zz_ff, s3_t_ff);
      s4_zs_ff  <= p_zs_ff;
      s4_xs_ff  <= p_xs_ff;
      s4_ys_ff  <= p_ys_ff;
      s4_xsh_ff <= p_xsh_ff;
      s4_ch_ff  <= s3_ch_ff;
      // pole test value and atan2 operands
      s5_v_ff   <= p_xyt_ff + s4_zs_ff;
      s5_nh_ff  <= s4_xs_ff - p_yzt_ff;
      s5_dh_ff  <= ONE_Q - p_xzzt_ff;
      s5_na_ff  <= s4_ys_ff - p_xzt_ff;
      s5_da_ff  <= ONE_Q - p_yzzt_ff;
      s5_xsh_ff <= s4_xsh_ff;
      s5_ch_ff  <= s4_ch_ff;
   end

   // ---------------------------------------------------------------- S6..S8 pole, radicand
   logic signed [DW-1:0] thr_q;
   mid_type              s6_mid_in, s6_mid_ff, s7_mid_ff, s8_mid_ff;
   logic signed [29:0]   vc_n;
   logic signed [59:0]   vc_sq;
   logic [SQ_NW-1:0]     s7_sq_ff;
   sqrt_type             s8_sq_ff;

   assign thr_q = DW'({thr_ff, 14'b0});

   always_comb begin
      s6_mid_in.head_y = s5_nh_ff;
      s6_mid_in.head_x = s5_dh_ff;
      if (s5_v_ff > thr_q) s6_mid_in.pole = POLE_NORTH;
      else if (s5_v_ff < -thr_q) s6_mid_in.pole = POLE_SOUTH;
      else s6_mid_in.pole = POLE_REGULAR;
      if (s6_mid_in.pole != POLE_REGULAR) begin
         s6_mid_in.att_y = s5_xsh_ff;
         s6_mid_in.att_x = s5_ch_ff;
      end else begin
         s6_mid_in.att_y = s5_na_ff;
         s6_mid_in.att_x = s5_da_ff;
      end
      // clamp bank operand to +-1
      if (s5_v_ff > ONE_Q) s6_mid_in.vc = ONE_Q;
      else if (s5_v_ff < -ONE_Q) s6_mid_in.vc = -ONE_Q;
      else s6_mid_in.vc = s5_v_ff;
   end

   assign vc_n  = s6_mid_ff.vc[29:0];
   assign vc_sq = vc_n * vc_n;

   always_ff @(posedge clock) begin
      s6_mid_ff    <= s6_mid_in;
      s7_mid_ff    <= s6_mid_ff;
      s7_sq_ff     <= vc_sq[SQ_NW-1:0];
      s8_mid_ff    <= s7_mid_ff;
      s8_sq_ff.n   <= ONE_SQ - s7_sq_ff;
      s8_sq_ff.res <= '0;
   end

   // ---------------------------------------------------------------- square root row
   sqrt_type sq_w [SQ_STEPS+1];
   mid_type  mid_dly_ff [SQ_STEPS];

   assign sq_w[0] = s8_sq_ff;

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
      aae_sqrt_cell #(.IDX(k)) u_sqrt (
         .clock(clock), .prev_data(sq_w[k]), .next_data(sq_w[k+1]));
   end

   always_ff @(posedge clock) begin
      mid_dly_ff[0] <= s8_mid_ff;
      for (int k = 1; k < SQ_STEPS; k++) mid_dly_ff[k] <= mid_dly_ff[k-1];
   end

   // ---------------------------------------------------------------- atan2 rows
   mid_type    mid_end;
   vec_type    vh_start_ff, va_start_ff, vb_start_ff;
   vec_type    vh_w [N+1];
   vec_type    va_w [N+1];
   vec_type    vb_w [N+1];
   logic [1:0] sv_pole_ff;
   logic [1:0] pole_dly_ff [N];

   assign mid_end = mid_dly_ff[SQ_STEPS-1];

   always_ff @(posedge clock) begin
      vh_start_ff <= vec_start(mid_end.head_y, mid_end.head_x);
      va_start_ff <= vec_start(mid_end.att_y, mid_end.att_x);
      vb_start_ff <= vec_start(mid_end.vc, DW'(sq_w[SQ_STEPS].res));
      sv_pole_ff <= mid_end.pole;
      pole_dly_ff[0] <= sv_pole_ff;
      for (int k = 1; k < N; k++) pole_dly_ff[k] <= pole_dly_ff[k-1];
   end

   assign vh_w[0] = vh_start_ff;
   assign va_w[0] = va_start_ff;
   assign vb_w[0] = vb_start_ff;

   for (genvar k = 0; k < N; k++) begin : g_vec
      aae_vec_cell #(.IDX(k)) u_vh (
         .clock(clock), .prev_data(vh_w[k]), .next_data(vh_w[k+1]));
      aae_vec_cell #(.IDX(k)) u_va (
         .clock(clock), .prev_data(va_w[k]), .next_data(va_w[k+1]));
      aae_vec_cell #(.IDX(k)) u_vb (
         .clock(clock), .prev_data(vb_w[k]), .next_data(vb_w[k+1]));
   end

   // ---------------------------------------------------------------- select, round
   logic signed [DW-1:0] head_a, att_a, bank_a, att2;
   logic signed [DW-1:0] sel_head_ff, sel_att_ff, sel_bank_ff;
   logic [1:0]           pole_end, sel_pole_ff;
   rsp_type              rsp_data_ff;

   assign pole_end = pole_dly_ff[N-1];
   assign head_a   = vh_w[N].zero ? '0 : vh_w[N].z;
   assign att_a    = va_w[N].zero ? '0 : va_w[N].z;
   assign bank_a   = vb_w[N].zero ? '0 : vb_w[N].z;
   assign att2     = att_a <<< 1;

   always_ff @(posedge clock) begin
      sel_pole_ff <= pole_end;
      case (pole_end)
         POLE_NORTH: begin
            sel_head_ff <= '0;
            sel_att_ff  <= att2;
            sel_bank_ff <= HALF_PI_Q;
         end
         POLE_SOUTH: begin
            sel_head_ff <= '0;
            sel_att_ff  <= -att2;
            sel_bank_ff <= -HALF_PI_Q;
         end
         default: begin
            sel_head_ff <= head_a;
            sel_att_ff  <= att_a;
            sel_bank_ff <= bank_a;
         end
      endcase
      rsp_data_ff.heading_angle  <= to_out(sel_head_ff);
      rsp_data_ff.attitude_angle <= to_out(sel_att_ff);
      rsp_data_ff.bank_angle     <= to_out(sel_bank_ff);
      rsp_data_ff.pole_case      <= sel_pole_ff;
   end

   assign rsp_data = rsp_data_ff;

   // ---------------------------------------------------------------- assertions
   `AAE_ASSERT_DELAY(a_fixed_latency, clock, reset, accept, LATENCY, rsp_valid,
      "request did not produce a result at the pipeline latency")
   `AAE_ASSERT_IMPL(a_pole_heading, clock, reset,
      rsp_valid && rsp_data.pole_case != POLE_REGULAR, rsp_data.heading_angle == 16'sd0,
      "pole result with nonzero heading")
   `AAE_ASSERT_IMPL(a_north_bank, clock, reset,
      rsp_valid && rsp_data.pole_case == POLE_NORTH, rsp_data.bank_angle == POLE_BANK_N,
      "north pole result with wrong bank")
   `AAE_ASSERT_IMPL(a_south_bank, clock, reset,
      rsp_valid && rsp_data.pole_case == POLE_SOUTH, rsp_data.bank_angle == POLE_BANK_S,
      "south pole result with wrong bank")
endmodule

### test/axis_angle_to_euler_unit_test.sv
// Self-checking bench for axis_angle_to_euler_unit: directed and random poses are
// converted by a local fixed-point predictor and compared field by field.
// Depends on aae_pkg and the axis_angle_to_euler_unit RTL.
module axis_angle_to_euler_unit_test;
   import aae_pkg::*;

   localparam int NUM_STAGES = 16;
   localparam int LATENCY    = 2 * NUM_STAGES + 41;
   localparam longint Q_ONE  = 64'sd1 <<< 28;
   localparam longint Q_PI   = 64'sd843314857;
   localparam longint Q_HPI  = 64'sd421657428;
   localparam longint Q_GAIN = 64'sd163008218;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_valid;
   rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_AW-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   // current threshold as the block sees it
   logic [14:0] threshold_q = POLE_THR_RESET;
   rsp_type euler_queue[$];
   int mismatch_count = 0;
   bit idle_enable = 1'b1;

   longint arctan_q28[24] = '{
      64'h0C90FDAA, 64'h076B19C1, 64'h03EB6EBF, 64'h01FD5BA9, 64'h00FFAADD, 64'h007FF556,
      64'h003FFEAA, 64'h001FFFD5, 64'h000FFFFA, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF,
      64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F, 64'h0000001F};

   axis_angle_to_euler_unit i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   // Q28 product, floor rounding
   function automatic longint qmul(input longint a, input longint b);
      return (a * b) >>> 28;
   endfunction

   // rotation-mode CORDIC with folding into +-pi/2
   function automatic void sin_cos(input longint ang, output longint sn, output longint cs);
      longint x, y, nx;
      bit flip;
      x = Q_GAIN;
      y = 0;
      flip = 1'b0;
      if (ang > Q_HPI) begin
         ang -= Q_PI;
         flip = 1'b1;
      end else if (ang < -Q_HPI) begin
         ang += Q_PI;
         flip = 1'b1;
      end
      for (int i = 0; i < NUM_STAGES; i++) begin
         if (ang >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            ang -= arctan_q28[i];
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            ang += arctan_q28[i];
         end
         x = nx;
      end
      sn = flip ? -y : y;
      cs = flip ? -x : x;
   endfunction

   // vectoring-mode CORDIC
   function automatic longint arctan2(input longint y, input longint x);
      longint z, nx;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         z = (y >= 0) ? Q_PI : -Q_PI;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < NUM_STAGES; i++) begin
         if (y >= 0) begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += arctan_q28[i];
         end else begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= arctan_q28[i];
         end
         x = nx;
      end
      return z;
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned n);
      longint unsigned root, b;
      root = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= root + b) begin
            n -= root + b;
            root = (root >> 1) + b;
         end else begin
            root >>= 1;
         end
         b >>= 2;
      end
      return root;
   endfunction

   // round half up to Q3.13 and saturate
   function automatic logic signed [15:0] to_q13(input longint v);
      longint r;
      r = (v + 64'sd16384) >>> 15;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return 16'(r);
   endfunction

   function automatic rsp_type predict_euler(input req_type d, input logic [14:0] thr_reg);
      longint x, y, z, w, thr, s, c, t, v, head, att, bank, sh, ch, num, den, vc, r;
      rsp_type o;
      x = longint'(d.axis_x) <<< 14;
      y = longint'(d.axis_y) <<< 14;
      z = longint'(d.axis_z) <<< 14;
      w = longint'(d.rotation_angle) <<< 15;
      thr = longint'({1'b0, thr_reg}) <<< 14;
      sin_cos(w, s, c);
      t = Q_ONE - c;
      v = qmul(qmul(x, y), t) + qmul(z, s);
      if (v > thr || v < -thr) begin
         o.pole_case = (v > thr) ? POLE_NORTH : POLE_SOUTH;
         sin_cos(w >>> 1, sh, ch);
         att = 2 * arctan2(qmul(x, sh), ch);
         head = 0;
         bank = Q_HPI;
         if (o.pole_case == POLE_SOUTH) begin
            att = -att;
            bank = -bank;
         end
      end else begin
         o.pole_case = POLE_REGULAR;
         num = qmul(x, s) - qmul(qmul(y, z), t);
         den = Q_ONE - qmul(qmul(x, x) + qmul(z, z), t);
         head = arctan2(num, den);
         num = qmul(y, s) - qmul(qmul(x, z), t);
         den = Q_ONE - qmul(qmul(y, y) + qmul(z, z), t);
         att = arctan2(num, den);
         vc = v;
         if (vc > Q_ONE) vc = Q_ONE;
         if (vc < -Q_ONE) vc = -Q_ONE;
         r = longint'(int_sqrt(longint'(unsigned'(Q_ONE * Q_ONE - vc * vc))));
         bank = arctan2(vc, r);
      end
      o.heading_angle = to_q13(head);
      o.attitude_angle = to_q13(att);
      o.bank_angle = to_q13(bank);
      return o;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   // record the expected result of each accepted request
   always @(posedge clock) begin
      if (!reset && start && !busy) euler_queue.push_back(predict_euler(req_data, threshold_q));
   end

   // compare each result with the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (euler_queue.size() == 0) begin
            report_mismatch("unexpected result, pole_case", rsp_data.pole_case, -1);
         end else begin
            want = euler_queue.pop_front();
            if (rsp_data.heading_angle !== want.heading_angle)
               report_mismatch("heading", rsp_data.heading_angle, want.heading_angle);
            if (rsp_data.attitude_angle !== want.attitude_angle)
               report_mismatch("attitude", rsp_data.attitude_angle, want.attitude_angle);
            if (rsp_data.bank_angle !== want.bank_angle)
               report_mismatch("bank", rsp_data.bank_angle, want.bank_angle);
            if (rsp_data.pole_case !== want.pole_case)
               report_mismatch("pole_case", rsp_data.pole_case, want.pole_case);
         end
      end
   end

   // send one request, with an occasional idle burst before it
   task automatic send_pose(input req_type d);
      if (idle_enable && $urandom_range(3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= d;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain();
      start <= 1'b0;
      wait (euler_queue.size() == 0);
      @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [31:0] value);
      drain();
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= CSR_AW'(4 * CSR_POLE_THRESHOLD);
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      threshold_q = value[14:0];
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      // read back the register at the same address
      if (!pready || prdata !== {17'd0, value[14:0]})
         report_mismatch("threshold readback", int'(prdata), int'(value[14:0]));
   endtask

   function automatic req_type make_pose(input int ax, input int ay, input int az, input int w);
      req_type d;
      d.axis_x = 16'(ax);
      d.axis_y = 16'(ay);
      d.axis_z = 16'(az);
      d.rotation_angle = 16'(w);
      return d;
   endfunction

   // unit axis with random direction, or full-range noise
   function automatic req_type random_pose();
      real th, ph;
      if ($urandom_range(4) == 0)
         return req_type'({$urandom, $urandom});
      th = $urandom_range(0, 62831) / 10000.0;
      ph = $urandom_range(0, 31415) / 10000.0;
      return make_pose(int'(16384.0 * $sin(ph) * $cos(th)), int'(16384.0 * $sin(ph) * $sin(th)),
                       int'(16384.0 * $cos(ph)), int'($urandom_range(0, 65535)) - 32768);
   endfunction

   // extremes, zero cases and both poles
   task automatic test_directed();
      send_pose(make_pose(0, 0, 0, 0));
      send_pose(make_pose(16384, 0, 0, 0));
      send_pose(make_pose(0, 16384, 0, 12868));
      send_pose(make_pose(16384, 0, 0, 12868));
      send_pose(make_pose(0, 0, 16384, 12868));
      send_pose(make_pose(0, 0, 16384, -12868));
      send_pose(make_pose(0, 0, 16384, 25736));
      send_pose(make_pose(11585, 11585, 0, 25736));
      send_pose(make_pose(11585, -11585, 0, 25736));
      send_pose(make_pose(100, 0, 16384, 12868));
      send_pose(make_pose(-100, 0, -16384, 12868));
      send_pose(make_pose(32767, 32767, 32767, 32767));
      send_pose(make_pose(-32768, -32768, -32768, -32768));
      send_pose(make_pose(32767, -32768, 0, 32767));
      send_pose(make_pose(-32768, 32767, 32767, -32768));
      send_pose(make_pose(0, 0, 32767, 12868));
      send_pose(make_pose(16384, 16384, 0, -25736));
      send_pose(make_pose(9459, 9459, 9459, 3000));
      send_pose(make_pose(0, 0, 0, 32767));
   endtask

   task automatic test_random(input int count);
      for (int k = 0; k < count; k++) send_pose(random_pose());
   endtask

   // threshold extremes shift the pole decision
   task automatic test_thresholds();
      write_threshold(32'd0);
      test_directed();
      test_random(60);
      write_threshold(32'd16384);
      test_directed();
      test_random(60);
      write_threshold(32'hFFFF_FFFF);
      test_random(40);
      write_threshold($urandom_range(16000, 16384));
      test_random(60);
      write_threshold({17'd0, POLE_THR_RESET});
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(120);
      test_thresholds();
      // last stretch back to back
      idle_enable = 1'b0;
      test_random(50);
      drain();
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #3_000_000;
      $display("Mismatches found");
      $finish;
   end
endmodule
